FILE: src/assert_macros.svh
// assertion macros shared by the rtl of the interrupt line controller
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/exld_pkg.sv
// shared types, codes and helpers of the interrupt line controller
// no dependencies; imported by every module of the block
package exld_pkg;

	localparam int PORT_MAX   = 4;
	localparam int LINE_COUNT = 16;
	localparam int LINE_W     = 4;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 48;

	localparam logic [2:0] ACT_ATTACH  = 3'd0;
	localparam logic [2:0] ACT_DETACH  = 3'd1;
	localparam logic [2:0] ACT_COUNT   = 3'd2;
	localparam logic [2:0] ACT_OWNS    = 3'd3;
	localparam logic [2:0] ACT_EDGE    = 3'd4;
	localparam logic [2:0] ACT_RELEASE = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_PIN = 3'd1;
	localparam logic [2:0] ST_BAD_ARG = 3'd2;
	localparam logic [2:0] ST_BUSY    = 3'd3;
	localparam logic [2:0] ST_HANDLER = 3'd4;

	localparam logic [2:0]  CFG_DEBOUNCE   = 3'd4;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

	localparam logic [3:0] GROUP_MID_LINE  = 4'd5;
	localparam logic [3:0] GROUP_HIGH_LINE = 4'd10;
	localparam logic [2:0] GROUP_MID       = 3'd5;
	localparam logic [2:0] GROUP_HIGH      = 3'd6;

	typedef logic [PORT_MAX-1:0][15:0] mask_arr_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	function automatic logic [2:0] group_of(input logic [LINE_W-1:0] line);
		logic [2:0] grp;
		if (line < GROUP_MID_LINE) begin
			grp = line[2:0];
		end else if (line < GROUP_HIGH_LINE) begin
			grp = GROUP_MID;
		end else begin
			grp = GROUP_HIGH;
		end
		return grp;
	endfunction

endpackage

FILE: src/exld_cfg.sv
// configuration registers: reserved pin masks per port and debounce window
// depends on exld_pkg
module exld_cfg #(
	parameter int PORT_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output exld_pkg::mask_arr_t masks,
	output logic [15:0]       window
);
	import exld_pkg::*;

	logic [15:0] window_q;

	assign cfg_ready = 1'b1;
	assign window    = window_q;

	for (genvar p = 0; p < PORT_MAX; p++) begin : g_mask
		if (p < PORT_COUNT) begin : g_used
			logic [15:0] mask_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mask_q <= '0;
				end else if (cfg_valid && cfg_index == 3'(p)) begin
					mask_q <= cfg_data;
				end
			end
			assign masks[p] = mask_q;
		end else begin : g_unused
			assign masks[p] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_index == CFG_DEBOUNCE) begin
			window_q <= cfg_data;
		end
	end

endmodule

FILE: src/exld_ctrl.sv
// controller: accepts one word, executes it, holds the result handshake
// depends on exld_pkg
module exld_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output exld_pkg::ctrl_cmd_t cmd
);
	import exld_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic m_valid_q;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/exld_dpath.sv
// datapath: input word register, per-line state, one read-modify-write per word
// depends on exld_pkg; driven by exld_ctrl commands
module exld_dpath #(
	parameter int PORT_COUNT = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  exld_pkg::ctrl_cmd_t           cmd,
	input  logic [2:0]                    s_tuser,
	input  logic [exld_pkg::S_TDATA_W-1:0] s_tdata,
	input  exld_pkg::mask_arr_t           masks,
	input  logic [15:0]                   window,
	output logic [2:0]                    m_tuser,
	output logic [exld_pkg::M_TDATA_W-1:0] m_tdata
);
	import exld_pkg::*;

	// input word
	logic [2:0]        act_q;
	logic [7:0]        pin_q;
	logic [7:0]        emode_q;
	logic              hcb_q;
	logic              inh_q;
	logic [LINE_W-1:0] eline_q;
	logic              dir_q;
	logic [31:0]       now_q;
	logic              active_q;

	// line state
	logic [LINE_COUNT-1:0][2:0]  mode_q;
	logic [LINE_COUNT-1:0][1:0]  owner_q;
	logic [LINE_COUNT-1:0][31:0] cnt_q;
	logic [LINE_COUNT-1:0][31:0] last_q;
	logic [LINE_COUNT-1:0]       cb_q;
	logic [LINE_COUNT-1:0]       arm_r_q;
	logic [LINE_COUNT-1:0]       arm_f_q;

	// result word
	logic [2:0]  status_q;
	logic [31:0] count_q;
	logic        owns_q;
	logic        fire_q;
	logic [7:0]  fpin_q;
	logic [2:0]  grp_q;

	logic [LINE_W-1:0] pline;
	logic [3:0]        port;
	logic [LINE_W-1:0] ln;
	logic [2:0]        cur_mode;
	logic [1:0]        cur_own;
	logic [31:0]       cur_cnt;
	logic [31:0]       cur_last;
	logic              cur_cb;
	logic [31:0]       cnt_inc;
	logic [31:0]       since;
	logic              pin_ok;
	logic              owns;
	logic              armed;

	logic        wr_attach, wr_free, wr_disarm, wr_count, rel_all;
	logic [2:0]  status_d;
	logic [31:0] count_d;
	logic        owns_d;
	logic        fire_d;
	logic [7:0]  fpin_d;
	logic [2:0]  grp_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= s_tuser;
			pin_q    <= s_tdata[7:0];
			emode_q  <= s_tdata[15:8];
			hcb_q    <= s_tdata[16];
			inh_q    <= s_tdata[17];
			eline_q  <= s_tdata[21:18];
			dir_q    <= s_tdata[22];
			now_q    <= s_tdata[54:23];
			active_q <= s_tdata[55];
		end
	end

	assign pline    = pin_q[3:0];
	assign port     = pin_q[7:4];
	assign ln       = (act_q == ACT_EDGE) ? eline_q : pline;
	assign cur_mode = mode_q[ln];
	assign cur_own  = owner_q[ln];
	assign cur_cnt  = cnt_q[ln];
	assign cur_last = last_q[ln];
	assign cur_cb   = cb_q[ln];
	assign cnt_inc  = cur_cnt + 32'd1;
	assign since    = now_q - cur_last;
	assign pin_ok   = (port < 4'(PORT_COUNT)) && !masks[port[1:0]][pline];
	assign owns     = pin_ok && (cur_mode != 3'd0) && (cur_own == pin_q[5:4]);
	assign armed    = dir_q ? arm_f_q[ln] : arm_r_q[ln];

	always_comb begin
		wr_attach = 1'b0;
		wr_free   = 1'b0;
		wr_disarm = 1'b0;
		wr_count  = 1'b0;
		rel_all   = 1'b0;
		status_d  = ST_OK;
		count_d   = '0;
		owns_d    = 1'b0;
		fire_d    = 1'b0;
		fpin_d    = '0;
		grp_d     = group_of(ln);
		unique case (act_q)
			ACT_ATTACH: begin
				if (emode_q[1:0] == 2'd0 || emode_q[7:3] != 5'd0) begin
					status_d = ST_BAD_ARG;
				end else if (inh_q) begin
					status_d = ST_HANDLER;
				end else if (!pin_ok) begin
					status_d = ST_BAD_PIN;
				end else if (cur_mode != 3'd0 && cur_own != pin_q[5:4]) begin
					status_d = ST_BUSY;
				end else begin
					wr_attach = 1'b1;
				end
			end
			ACT_DETACH: begin
				if (inh_q) begin
					status_d = ST_HANDLER;
				end else if (!owns) begin
					status_d = ST_BAD_ARG;
				end else begin
					wr_free = 1'b1;
				end
			end
			ACT_COUNT: begin
				if (owns) begin
					count_d = cur_cnt;
				end
			end
			ACT_OWNS: begin
				owns_d = owns;
			end
			ACT_EDGE: begin
				count_d = cur_cnt;
				if (armed) begin
					if (cur_mode == 3'd0 || !active_q) begin
						wr_disarm = 1'b1;
					end else if (!(cur_mode[2] && cur_cnt != 32'd0 &&
							since < {16'd0, window})) begin
						wr_count = 1'b1;
						count_d  = cnt_inc;
						fpin_d   = {2'b00, cur_own, ln};
						fire_d   = cur_cb;
					end
				end
			end
			ACT_RELEASE: begin
				rel_all = 1'b1;
				grp_d   = 3'd0;
			end
			default: begin
				status_d = ST_BAD_ARG;
				grp_d    = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			owner_q <= '0;
			cnt_q   <= '0;
			last_q  <= '0;
			cb_q    <= '0;
			arm_r_q <= '0;
			arm_f_q <= '0;
		end else if (cmd.exec) begin
			if (wr_attach) begin
				cb_q[ln]    <= hcb_q;
				cnt_q[ln]   <= '0;
				last_q[ln]  <= '0;
				owner_q[ln] <= pin_q[5:4];
				mode_q[ln]  <= emode_q[2:0];
				arm_r_q[ln] <= emode_q[0];
				arm_f_q[ln] <= emode_q[1];
			end
			if (wr_free) begin
				mode_q[ln]  <= '0;
				cb_q[ln]    <= 1'b0;
				cnt_q[ln]   <= '0;
				arm_r_q[ln] <= 1'b0;
				arm_f_q[ln] <= 1'b0;
			end
			if (wr_disarm) begin
				arm_r_q[ln] <= 1'b0;
				arm_f_q[ln] <= 1'b0;
			end
			if (wr_count) begin
				last_q[ln] <= now_q;
				cnt_q[ln]  <= cnt_inc;
			end
			if (rel_all) begin
				for (int i = 0; i < LINE_COUNT; i++) begin
					if (mode_q[i] != 3'd0) begin
						mode_q[i]  <= '0;
						cb_q[i]    <= 1'b0;
						cnt_q[i]   <= '0;
						arm_r_q[i] <= 1'b0;
						arm_f_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			count_q  <= count_d;
			owns_q   <= owns_d;
			fire_q   <= fire_d;
			fpin_q   <= fpin_d;
			grp_q    <= grp_d;
		end
	end

	assign m_tuser = status_q;
	assign m_tdata = {3'b000, grp_q, fpin_q, fire_q, owns_q, count_q};

endmodule

FILE: src/exti_line_owner_debounce_top.sv
// channel   | handshake          | payload
// s (word)  | s_tvalid, s_tready | s_tuser action, s_tdata request fields
// m (word)  | m_tvalid, m_tready | m_tuser status, m_tdata result fields
// cfg       | cfg_valid, cfg_ready | cfg_index register, cfg_data value
// a word is first registered, then its line gets one read-modify-write (every line on a release)
// the line state sits in flip-flops; the next word is accepted only after the last one has executed
// a waiting result does not block acceptance of the next word, only its execution
// arst_n clears line ownership, arming, counts and masks; window resets to 20 ms
// cfg_ready is always high
// top level of the interrupt line controller; depends on exld_pkg, exld_cfg,
// exld_ctrl, exld_dpath and assert_macros.svh
module exti_line_owner_debounce_top #(
	parameter int PORT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0]
	input  logic [2:0]  s_tuser,
	// pin_id[7:0], edge_mode[15:8], has_callback[16], in_handler[17],
	// line_index[21:18], edge_direction[22], now_ms[54:23], app_active[55]
	input  logic [exld_pkg::S_TDATA_W-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0]
	output logic [2:0]  m_tuser,
	// count_value[31:0], owns_line[32], fire_handler[33], fire_pin[41:34],
	// irq_group[44:42], zero fill[47:45]
	output logic [exld_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import exld_pkg::*;

	ctrl_cmd_t   cmd;
	mask_arr_t   masks;
	logic [15:0] window;

	exld_cfg #(
		.PORT_COUNT(PORT_COUNT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.masks    (masks),
		.window   (window)
	);

	exld_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	exld_dpath #(
		.PORT_COUNT(PORT_COUNT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.masks  (masks),
		.window (window),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata)
	);

`include "assert_macros.svh"

	`ASSERT_NEXT(a_exec_gives_result, clk, arst_n, cmd.exec, m_tvalid, "exec without result")
	`ASSERT_NEXT(a_one_word_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"second word accepted during execution")
	`ASSERT_SAME(a_no_overwrite, clk, arst_n, m_tvalid && !m_tready, !cmd.exec,
		"waiting result overwritten")
	`ASSERT_SAME(a_load_only_idle, clk, arst_n, cmd.load, s_tready && !cmd.exec,
		"word loaded outside idle")

endmodule
